>>> sv/resizable_array_index_engine_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resizable array index engine
// Shared property wrappers: clocked, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef RESIZABLE_ARRAY_INDEX_ENGINE_CORE_MACROS_SVH
`define RESIZABLE_ARRAY_INDEX_ENGINE_CORE_MACROS_SVH

// Same-cycle implication
`define RAIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RAIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/raie_pkg.sv
// ----------------------------------------------------------------------------
// raie_pkg
// Types, codes and helpers shared by the resizable array index engine.
// ----------------------------------------------------------------------------
package raie_pkg;

  // Request commands
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_GET  = 2'd2;

  // Index block resize codes
  localparam logic [1:0] RESIZE_NONE   = 2'd0;
  localparam logic [1:0] RESIZE_DOUBLE = 2'd1;
  localparam logic [1:0] RESIZE_HALVE  = 2'd2;

  // Register indexes (byte address bit 2)
  localparam logic REG_ELEMENT_BYTES = 1'b0;
  localparam logic REG_SEGMENT_LOG2  = 1'b1;

  localparam logic [3:0] SEG_LOG2_MAX    = 4'd8;
  localparam logic [7:0] ELEM_BYTES_INIT = 8'd8;
  localparam logic [3:0] SEG_LOG2_INIT   = 4'd2;
  localparam int         IDX_W           = 20;
  localparam int         CNT_W           = 42;

  typedef struct packed {
    logic [7:0] element_bytes;
    logic [3:0] segment_log2;
  } cfg_t;

  typedef struct packed {
    logic [32:0]      segments_used;
    logic [8:0]       last_segment_fill;
    logic [16:0]      last_block_fill;
    logic [16:0]      segments_per_block;
    logic [16:0]      blocks_per_super;
    logic [16:0]      last_super_fill;
    logic [5:0]       super_count;
    logic [17:0]      blocks_used;
    logic             spare_block;
    logic [IDX_W-1:0] index_size;
  } arr_state_t;

  typedef struct packed {
    logic        error;
    logic [17:0] block_index;
    logic [31:0] byte_offset;
    logic        alloc_request;
    logic [31:0] alloc_bytes;
    logic        free_request;
    logic [17:0] free_index;
    logic [1:0]  index_resize;
    logic [19:0] index_capacity;
    logic [31:0] element_count;
  } result_t;

  typedef struct packed {
    logic [17:0] block_index;
    logic [31:0] byte_offset;
  } map_t;

  // Elements per segment
  function automatic logic [8:0] seg_elems(input logic [3:0] s);
    return 9'(9'd1 << s);
  endfunction

  // Elements held by the counters
  function automatic logic [CNT_W-1:0] stored_count(input arr_state_t st,
                                                    input logic [3:0] s);
    logic [CNT_W-1:0] full_segs;
    full_segs = (CNT_W'(st.segments_used) - CNT_W'(1)) << s;
    if (st.segments_used == 33'd0) begin
      return '0;
    end
    return full_segs + CNT_W'(st.last_segment_fill);
  endfunction

  // Empty-array counters; index block size is kept
  function automatic arr_state_t restore_state(input logic [3:0] s,
                                               input logic [IDX_W-1:0] idx);
    arr_state_t st;
    st.segments_used      = '0;
    st.last_segment_fill  = seg_elems(s);
    st.last_block_fill    = 17'd1;
    st.segments_per_block = 17'd1;
    st.blocks_per_super   = 17'd1;
    st.last_super_fill    = '0;
    st.super_count        = 6'd1;
    st.blocks_used        = '0;
    st.spare_block        = 1'b1;
    st.index_size         = idx;
    return st;
  endfunction

endpackage

>>> sv/raie_get_map.sv
// ----------------------------------------------------------------------------
// raie_get_map
// Maps a logical position to its index-block entry and byte offset.
// ----------------------------------------------------------------------------
module raie_get_map
  import raie_pkg::*;
(
  input  logic [31:0] position,
  input  cfg_t        cfg,
  output map_t        map
);

  logic [7:0]  elm_mask;
  logic [7:0]  elm;
  logic [32:0] pos1;
  logic [5:0]  k;
  logic [4:0]  half;
  logic        odd;
  logic [4:0]  seg_bits;
  logic [16:0] blocks_here;
  logic [32:0] seg_mask;
  logic [16:0] seg;
  logic [16:0] blk;
  logic [18:0] first;
  logic [24:0] slot;
  logic [32:0] prod;

  // Split position into segment number and element within segment
  assign elm_mask = 8'((9'd1 << cfg.segment_log2) - 9'd1);
  assign elm      = position[7:0] & elm_mask;
  assign pos1     = 33'(position >> cfg.segment_log2) + 33'd1;

  // Leading one of the segment number
  always_comb begin
    k = '0;
    for (int i = 0; i < 33; i++) begin
      if (pos1[i]) begin
        k = 6'(i);
      end
    end
  end

  // Superblock geometry
  assign half        = k[5:1];
  assign odd         = k[0];
  assign seg_bits    = half + 5'(odd);
  assign blocks_here = 17'(17'd1 << half);
  assign seg_mask    = (33'd1 << seg_bits) - 33'd1;
  assign seg         = 17'(pos1 & seg_mask);
  assign blk         = 17'(pos1 >> seg_bits) & (blocks_here - 17'd1);
  assign first       = (19'(blocks_here - 17'd1) << 1) + (odd ? 19'(blocks_here) : 19'd0);

  // Entry and byte offset
  assign slot = (25'(seg) << cfg.segment_log2) | 25'(elm);
  assign prod = 33'(slot) * 33'(cfg.element_bytes);

  assign map.block_index = 18'(first + 19'(blk));
  assign map.byte_offset = prod[31:0];

endmodule

>>> sv/raie_step.sv
// ----------------------------------------------------------------------------
// raie_step
// Next counters and result of one push, pop or get request.
// ----------------------------------------------------------------------------
module raie_step
  import raie_pkg::*;
(
  input  logic [1:0]  command,
  input  logic [31:0] position,
  input  cfg_t        cfg,
  input  arr_state_t  st,
  output arr_state_t  st_nxt,
  output result_t     res
);

  logic [CNT_W-1:0] cnt;
  logic [8:0]       seg;
  logic [15:0]      seg_bytes;
  logic [32:0]      alloc_prod;
  logic [25:0]      push_slot;
  logic [33:0]      push_prod;
  logic [8:0]       lsf_dec;
  logic [16:0]      lbf_dec;
  logic [16:0]      lsuf_dec;
  map_t             map;

  assign cnt       = stored_count(st, cfg.segment_log2);
  assign seg       = seg_elems(cfg.segment_log2);
  assign seg_bytes = 16'(cfg.element_bytes) << cfg.segment_log2;
  assign lsf_dec   = st.last_segment_fill - 9'd1;
  assign lbf_dec   = st.last_block_fill - 17'd1;
  assign lsuf_dec  = st.last_super_fill - 17'd1;

  raie_get_map u_get_map (
    .position (position),
    .cfg      (cfg),
    .map      (map)
  );

  // Update counters and build the result
  always_comb begin
    st_nxt     = st;
    res        = '0;
    alloc_prod = '0;
    push_slot  = '0;
    push_prod  = '0;
    unique case (command)
      CMD_PUSH: begin
        if (cnt >= CNT_W'(32'hFFFF_FFFF)) begin
          res.error = 1'b1;
        end else begin
          if (st.last_segment_fill < seg) begin
            st_nxt.last_segment_fill = st.last_segment_fill + 9'd1;
          end else begin
            if (st.last_block_fill == st.segments_per_block) begin
              // Open a new superblock when this one is full
              if (st.last_super_fill == st.blocks_per_super) begin
                st_nxt.super_count = st.super_count + 6'd1;
                if (st_nxt.super_count[0]) begin
                  st_nxt.blocks_per_super = st.blocks_per_super << 1;
                end else begin
                  st_nxt.segments_per_block = st.segments_per_block << 1;
                end
                st_nxt.last_super_fill = '0;
              end
              // Allocate unless the spare block is reused
              if (!st.spare_block) begin
                if (IDX_W'(st.blocks_used) == st.index_size) begin
                  st_nxt.index_size = st.index_size << 1;
                  res.index_resize  = RESIZE_DOUBLE;
                end
                // Size of a new data block, with the block size after this push
                alloc_prod        = 33'(seg_bytes) * 33'(st_nxt.segments_per_block);
                res.alloc_request = 1'b1;
                res.alloc_bytes   = alloc_prod[31:0];
              end
              st_nxt.spare_block     = 1'b0;
              st_nxt.blocks_used     = st.blocks_used + 18'd1;
              st_nxt.last_super_fill = st_nxt.last_super_fill + 17'd1;
              st_nxt.last_block_fill = '0;
            end
            st_nxt.segments_used     = st.segments_used + 33'd1;
            st_nxt.last_block_fill   = st_nxt.last_block_fill + 17'd1;
            st_nxt.last_segment_fill = 9'd1;
          end
          // Offset of the pushed slot
          push_slot = (26'(st_nxt.last_block_fill - 17'd1) << cfg.segment_log2)
                    + 26'(st_nxt.last_segment_fill - 9'd1);
          push_prod = 34'(push_slot) * 34'(cfg.element_bytes);
          res.block_index = st_nxt.blocks_used - 18'd1;
          res.byte_offset = push_prod[31:0];
        end
      end
      CMD_POP: begin
        if (st.segments_used == 33'd0) begin
          res.error = 1'b1;
        end else if (lsf_dec != 9'd0) begin
          st_nxt.last_segment_fill = lsf_dec;
        end else begin
          st_nxt.segments_used = st.segments_used - 33'd1;
          if (lbf_dec == 17'd0) begin
            // Release any spare block; halve the index block when it exceeds four times the blocks used
            if (st.spare_block) begin
              res.free_request = 1'b1;
              res.free_index   = st.blocks_used;
            end
            if (st.index_size > {st.blocks_used, 2'b00}) begin
              st_nxt.index_size = st.index_size >> 1;
              res.index_resize  = RESIZE_HALVE;
            end
            st_nxt.blocks_used = st.blocks_used - 18'd1;
            if (lsuf_dec == 17'd0) begin
              // Step back to the previous superblock
              st_nxt.super_count = st.super_count - 6'd1;
              if (!st_nxt.super_count[0]) begin
                st_nxt.blocks_per_super = st.blocks_per_super >> 1;
              end else begin
                st_nxt.segments_per_block = st.segments_per_block >> 1;
              end
              st_nxt.last_super_fill = st_nxt.blocks_per_super;
            end else begin
              st_nxt.last_super_fill = lsuf_dec;
            end
            st_nxt.last_block_fill = st_nxt.segments_per_block;
            st_nxt.spare_block     = 1'b1;
          end else begin
            st_nxt.last_block_fill = lbf_dec;
          end
          if (st_nxt.segments_used == 33'd0) begin
            st_nxt = restore_state(cfg.segment_log2, st_nxt.index_size);
          end
          st_nxt.last_segment_fill = seg;
        end
      end
      CMD_GET: begin
        if (CNT_W'(position) >= cnt) begin
          res.error = 1'b1;
        end else begin
          res.block_index = map.block_index;
          res.byte_offset = map.byte_offset;
        end
      end
      default: begin
      end
    endcase
    res.index_capacity = st_nxt.index_size;
    res.element_count  = 32'(stored_count(st_nxt, cfg.segment_log2));
  end

endmodule

>>> sv/resizable_array_index_engine_core.sv
// ----------------------------------------------------------------------------
// resizable_array_index_engine_core
// Occupancy bookkeeping and address mapping for a superblock resizable array.
// ----------------------------------------------------------------------------
// Takes one push, pop or get request per clock while in_stall is low and returns
// one result per request. Each request passes the input register and then the
// result register; the counter update and the address mapping run combinationally
// between those two registers, so back-to-back requests see each other's counters
// without a bubble. A waiting result does not block the next request from entering
// an empty input register; a further request stalls while the result waits. Registers are at byte
// address 0 (element_bytes) and 4 (segment_log2); write them only while no
// request is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module resizable_array_index_engine_core
  import raie_pkg::*;
#(
  parameter int POSITION_BITS      = 32,
  parameter int INITIAL_INDEX_SIZE = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_command,
  input  logic [POSITION_BITS-1:0] in_position,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_error,
  output logic [17:0]              out_block_index,
  output logic [31:0]              out_byte_offset,
  output logic                     out_alloc_request,
  output logic [31:0]              out_alloc_bytes,
  output logic                     out_free_request,
  output logic [17:0]              out_free_index,
  output logic [1:0]               out_index_resize,
  output logic [19:0]              out_index_capacity,
  output logic [31:0]              out_element_count,
  // Register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int POS_KEEP = (POSITION_BITS < 32) ? POSITION_BITS : 32;

  logic        a_valid_r;
  logic [1:0]  a_cmd_r;
  logic [31:0] a_pos_r;
  logic        out_valid_r;
  result_t     res_r;
  cfg_t        cfg_r;
  arr_state_t  st_r;
  arr_state_t  st_nxt;
  arr_state_t  step_st;
  result_t     step_res;
  logic        advance;
  logic        load_a;
  logic        cfg_wr;
  logic [3:0]  seg_log2_sat;

  // Pipeline handshake
  assign advance  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !advance;
  assign load_a   = in_valid && !in_stall;

  // Register port decode
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign seg_log2_sat = (pwdata[3:0] > SEG_LOG2_MAX) ? SEG_LOG2_MAX : pwdata[3:0];

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ELEMENT_BYTES: prdata = 32'(cfg_r.element_bytes);
      REG_SEGMENT_LOG2:  prdata = 32'(cfg_r.segment_log2);
      default:           prdata = '0;
    endcase
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.element_bytes <= ELEM_BYTES_INIT;
      cfg_r.segment_log2  <= SEG_LOG2_INIT;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ELEMENT_BYTES) begin
        cfg_r.element_bytes <= pwdata[7:0];
      end else begin
        cfg_r.segment_log2 <= seg_log2_sat;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (load_a) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_cmd_r <= in_command;
      a_pos_r <= 32'(in_position[POS_KEEP-1:0]);
    end
  end

  raie_step u_step (
    .command  (a_cmd_r),
    .position (a_pos_r),
    .cfg      (cfg_r),
    .st       (st_r),
    .st_nxt   (step_st),
    .res      (step_res)
  );

  // Advance counters; a segment size write resizes the fill of an empty array
  always_comb begin
    st_nxt = st_r;
    if (advance) begin
      st_nxt = step_st;
    end
    if (cfg_wr && (paddr[2] == REG_SEGMENT_LOG2) && (st_r.segments_used == 33'd0)) begin
      st_nxt.last_segment_fill = seg_elems(seg_log2_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= restore_state(SEG_LOG2_INIT, IDX_W'(INITIAL_INDEX_SIZE));
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_error          = res_r.error;
  assign out_block_index    = res_r.block_index;
  assign out_byte_offset    = res_r.byte_offset;
  assign out_alloc_request  = res_r.alloc_request;
  assign out_alloc_bytes    = res_r.alloc_bytes;
  assign out_free_request   = res_r.free_request;
  assign out_free_index     = res_r.free_index;
  assign out_index_resize   = res_r.index_resize;
  assign out_index_capacity = res_r.index_capacity;
  assign out_element_count  = res_r.element_count;

endmodule

>>> sv/raie_checker.sv
// ----------------------------------------------------------------------------
// raie_checker
// Port-level checks on the result channel of the index engine.
// ----------------------------------------------------------------------------
`include "resizable_array_index_engine_core_macros.svh"

module raie_checker
  import raie_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_error,
  input logic [17:0] out_block_index,
  input logic [31:0] out_byte_offset,
  input logic        out_alloc_request,
  input logic        out_free_request,
  input logic [1:0]  out_index_resize,
  input logic [31:0] out_element_count
);

  // A stalled result holds
  `RAIE_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_block_index) && $stable(out_byte_offset) && $stable(out_element_count), "stalled result changed")

  // A refused request touches no block and no index size
  `RAIE_ASSERT_NOW(a_error_quiet, clk, rst_n, out_valid && out_error, !out_alloc_request && !out_free_request && (out_index_resize == RESIZE_NONE), "error result requests a change")

  // The index block grows only for a new data block
  `RAIE_ASSERT_NOW(a_double_alloc, clk, rst_n, out_valid && (out_index_resize == RESIZE_DOUBLE), out_alloc_request, "index doubled without allocation")

  // Allocation and release never share a request
  `RAIE_ASSERT_NOW(a_alloc_free, clk, rst_n, out_valid, !(out_alloc_request && out_free_request), "allocate and release together")

endmodule

bind resizable_array_index_engine_core raie_checker u_raie_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_error         (out_error),
  .out_block_index   (out_block_index),
  .out_byte_offset   (out_byte_offset),
  .out_alloc_request (out_alloc_request),
  .out_free_request  (out_free_request),
  .out_index_resize  (out_index_resize),
  .out_element_count (out_element_count)
);
